/* rtl/emf_pkg.sv */
// Shared types, constants and date helpers for the Easter movable feasts unit
`timescale 1ns / 1ps
package emf_pkg;

  // field widths
  localparam int YEAR_W = 14;
  localparam int DOM_W  = 5;
  localparam int MON_W  = 3;
  localparam int ORD_W  = 9;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // valid year range
  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1583;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

  // reciprocal multipliers for the constant divisions
  localparam int DIV100_MUL = 5243;   // y / 100 = (y * 5243) >> 19
  localparam int DIV100_SH  = 19;
  localparam int DIV19_MUL  = 27595;  // y / 19 = (y * 27595) >> 19
  localparam int DIV19_SH   = 19;
  localparam int DIV25_MUL  = 41;     // x / 25 = (x * 41) >> 10 for x < 172
  localparam int DIV3_MUL   = 171;    // x / 3 = (x * 171) >> 9 for x < 165
  localparam int DIV30_MUL  = 2185;   // x / 30 = (x * 2185) >> 16 for x < 1024
  localparam int DIV7_MUL   = 147;    // x / 7 = (x * 147) >> 10 for x < 128

  // computus constants
  localparam int H_BIAS    = 75;   // 15 plus 60 to keep the sum positive
  localparam int L_BIAS    = 67;   // 32 plus 35 to keep the sum positive
  localparam int M_LIMIT   = 451;
  localparam int BASE_BIAS = 114;
  localparam int APR_BASE  = 124;  // base value of 1 April

  // day offsets of the feasts
  localparam int CARNIVAL_BACK  = 49;
  localparam int FRIDAY_BACK    = 2;
  localparam int ASCENSION_FWD  = 39;
  localparam int PENTECOST_FWD  = 49;

  // month codes
  localparam logic [MON_W-1:0] MON_JAN = 3'd1;
  localparam logic [MON_W-1:0] MON_FEB = 3'd2;
  localparam logic [MON_W-1:0] MON_MAR = 3'd3;
  localparam logic [MON_W-1:0] MON_APR = 3'd4;
  localparam logic [MON_W-1:0] MON_MAY = 3'd5;
  localparam logic [MON_W-1:0] MON_JUN = 3'd6;
  localparam logic [MON_W-1:0] MON_JUL = 3'd7;

  // days before the first of each month in a common year
  localparam logic [ORD_W-1:0] END_JAN = 9'd31;
  localparam logic [ORD_W-1:0] END_FEB = 9'd59;
  localparam logic [ORD_W-1:0] END_MAR = 9'd90;
  localparam logic [ORD_W-1:0] END_APR = 9'd120;
  localparam logic [ORD_W-1:0] END_MAY = 9'd151;
  localparam logic [ORD_W-1:0] END_JUN = 9'd181;

  // item handed from front to back
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [7:0]        q100;
    logic [9:0]        q19;
    logic              in_range;
  } front_item_t;

  typedef struct packed {
    logic [MON_W-1:0] mon;
    logic [DOM_W-1:0] dom;
  } date_t;

  // one result transaction
  typedef struct packed {
    logic             year_in_range;
    logic             leap_flag;
    logic [DOM_W-1:0] easter_dom;
    logic [MON_W-1:0] easter_mon;
    logic [DOM_W-1:0] carnival_dom;
    logic [1:0]       carnival_mon;
    logic [DOM_W-1:0] friday_dom;
    logic [MON_W-1:0] friday_mon;
    logic [DOM_W-1:0] ascension_dom;
    logic [MON_W-1:0] ascension_mon;
    logic [DOM_W-1:0] pentecost_dom;
    logic [MON_W-1:0] pentecost_mon;
  } result_t;

  // day of year to month and day, first half of the year
  function automatic date_t ord_to_date(logic [ORD_W-1:0] ord, logic leap);
    logic [ORD_W-1:0] lp;
    logic [ORD_W-1:0] diff;
    date_t            r;
    lp = {{(ORD_W-1){1'b0}}, leap};
    if (ord <= END_JAN) begin
      r.mon = MON_JAN;
      diff  = ord;
    end else if (ord <= END_FEB + lp) begin
      r.mon = MON_FEB;
      diff  = ord - END_JAN;
    end else if (ord <= END_MAR + lp) begin
      r.mon = MON_MAR;
      diff  = ord - END_FEB - lp;
    end else if (ord <= END_APR + lp) begin
      r.mon = MON_APR;
      diff  = ord - END_MAR - lp;
    end else if (ord <= END_MAY + lp) begin
      r.mon = MON_MAY;
      diff  = ord - END_APR - lp;
    end else if (ord <= END_JUN + lp) begin
      r.mon = MON_JUN;
      diff  = ord - END_MAY - lp;
    end else begin
      r.mon = MON_JUL;
      diff  = ord - END_JUN - lp;
    end
    r.dom = diff[DOM_W-1:0];
    return r;
  endfunction

endpackage

/* rtl/emf_front.sv */
// Front stage: takes a year, checks its range and forms the century and cycle quotients
`timescale 1ns / 1ps
module emf_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [emf_pkg::YEAR_W-1:0]     in_year,
  output logic                           push,
  output emf_pkg::front_item_t           push_item,
  input  logic                           full
);

  logic                 f_v_r, f_v_nxt;
  emf_pkg::front_item_t item_r, item_nxt;
  logic [26:0]          p100;
  logic [28:0]          p19;
  logic                 take;

  // stage handshake: a held item leaves as soon as the queue has room
  assign in_ready  = !f_v_r || !full;
  assign take      = in_valid && in_ready;
  assign push      = f_v_r;
  assign push_item = item_r;

  // reciprocal products for y / 100 and y / 19
  always_comb begin
    p100 = 27'(in_year) * 27'(emf_pkg::DIV100_MUL);
    p19  = 29'(in_year) * 29'(emf_pkg::DIV19_MUL);
    item_nxt.year     = in_year;
    item_nxt.q100     = 8'(p100 >> emf_pkg::DIV100_SH);
    item_nxt.q19      = 10'(p19 >> emf_pkg::DIV19_SH);
    item_nxt.in_range = (in_year >= emf_pkg::YEAR_MIN) && (in_year <= emf_pkg::YEAR_MAX);
  end

  // valid flag of the front register
  always_comb begin
    if (take) begin
      f_v_nxt = 1'b1;
    end else if (f_v_r && !full) begin
      f_v_nxt = 1'b0;
    end else begin
      f_v_nxt = f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* rtl/emf_queue.sv */
// Short register queue between the front and the back
`timescale 1ns / 1ps
module emf_queue #(
  parameter int DEPTH = emf_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  emf_pkg::front_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output emf_pkg::front_item_t pop_item,
  output logic                 not_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  emf_pkg::front_item_t mem_r [DEPTH];
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // fill count never passes the depth
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  // a push and a pop together leave the count unchanged
  assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && do_pop) |=> $stable(count_r))
    else $error("queue count moved on push with pop");

endmodule

/* rtl/emf_back.sv */
// Back pipeline: computus steps, Easter date and the four feast dates
`timescale 1ns / 1ps
module emf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  emf_pkg::front_item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output emf_pkg::result_t     out_item
);

  // stage valid flags and enables
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, out_v_r;
  logic en1, en2, en3, en4, en5, en6, en_out;

  // stage 1 registers
  logic [4:0] s1_a_r, s1_a_nxt;
  logic [7:0] s1_b_r;
  logic [6:0] s1_c_r, s1_c_nxt;
  logic [2:0] s1_f_r, s1_f_nxt;
  logic [1:0] s1_ylo_r;
  logic       s1_inr_r;
  // stage 2 registers
  logic [9:0] s2_hsum_r, s2_hsum_nxt;
  logic [4:0] s2_a_r;
  logic [1:0] s2_e_r;
  logic [4:0] s2_i_r;
  logic [1:0] s2_k_r;
  logic       s2_leap_r, s2_leap_nxt;
  logic       s2_inr_r;
  // stage 3 registers
  logic [4:0] s3_h_r, s3_h_nxt;
  logic [4:0] s3_a_r;
  logic [1:0] s3_e_r;
  logic [4:0] s3_i_r;
  logic [1:0] s3_k_r;
  logic       s3_leap_r, s3_inr_r;
  // stage 4 registers
  logic [2:0] s4_l_r, s4_l_nxt;
  logic [4:0] s4_h_r;
  logic [4:0] s4_a_r;
  logic       s4_leap_r, s4_inr_r;
  // stage 5 registers
  logic       s5_apr_r, s5_apr_nxt;
  logic [4:0] s5_edom_r, s5_edom_nxt;
  logic       s5_leap_r, s5_inr_r;
  // stage 6 registers
  logic       s6_apr_r;
  logic [4:0] s6_edom_r;
  logic       s6_leap_r, s6_inr_r;
  logic [8:0] s6_carn_r, s6_carn_nxt;
  logic [8:0] s6_fri_r, s6_fri_nxt;
  logic [8:0] s6_asc_r, s6_asc_nxt;
  logic [8:0] s6_pen_r, s6_pen_nxt;
  // output register
  emf_pkg::result_t out_r, out_nxt;

  // combinational helpers
  logic [13:0] a_full, c_full, a_mul, c_mul;
  logic [7:0]  b8;
  logic [13:0] f_prod;
  logic [7:0]  gx;
  logic [15:0] g_prod;
  logic [5:0]  g, d;
  logic [21:0] hq_prod;
  logic [4:0]  hq;
  logic [9:0]  h_full;
  logic [6:0]  lsum, l_full;
  logic [14:0] lq_prod;
  logic [4:0]  lq;
  logic [8:0]  msum;
  logic        m_hit;
  logic [7:0]  base, edom_full;
  logic [8:0]  eord;
  emf_pkg::date_t carn_d, fri_d, asc_d, pen_d;

  // stall chain: a stage moves when empty or when the next one moves
  assign en_out = !out_v_r || out_ready;
  assign en6    = !s6_v_r || en_out;
  assign en5    = !s5_v_r || en6;
  assign en4    = !s4_v_r || en5;
  assign en3    = !s3_v_r || en4;
  assign en2    = !s2_v_r || en3;
  assign en1    = !s1_v_r || en2;
  assign q_pop  = q_valid && en1;

  assign out_valid = out_v_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= q_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
      if (en5) s5_v_r <= s4_v_r;
      if (en6) s6_v_r <= s5_v_r;
      if (en_out) out_v_r <= s6_v_r;
    end
  end

  // stage 1: golden number, year in century and century correction
  always_comb begin
    a_mul    = 14'(q_item.q19) * 14'(19);
    a_full   = q_item.year - a_mul;
    c_mul    = 14'(q_item.q100) * 14'(100);
    c_full   = q_item.year - c_mul;
    s1_a_nxt = a_full[4:0];
    s1_c_nxt = c_full[6:0];
    b8       = q_item.q100 + 8'd8;
    f_prod   = 14'(b8) * 14'(emf_pkg::DIV25_MUL);
    s1_f_nxt = f_prod[12:10];
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_a_r   <= s1_a_nxt;
      s1_b_r   <= q_item.q100;
      s1_c_r   <= s1_c_nxt;
      s1_f_r   <= s1_f_nxt;
      s1_ylo_r <= q_item.year[1:0];
      s1_inr_r <= q_item.in_range;
    end
  end

  // stage 2: epact sum before the mod 30, and the leap rule
  always_comb begin
    d           = s1_b_r[7:2];
    gx          = s1_b_r + 8'd1 - 8'(s1_f_r);
    g_prod      = 16'(gx) * 16'(emf_pkg::DIV3_MUL);
    g           = g_prod[14:9];
    s2_hsum_nxt = 10'(s1_a_r) * 10'(19) + 10'(s1_b_r) + 10'(emf_pkg::H_BIAS)
                  - 10'(d) - 10'(g);
    if (s1_c_r == 7'd0) begin
      s2_leap_nxt = (s1_b_r[1:0] == 2'd0);
    end else begin
      s2_leap_nxt = (s1_ylo_r == 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_hsum_r <= s2_hsum_nxt;
      s2_a_r    <= s1_a_r;
      s2_e_r    <= s1_b_r[1:0];
      s2_i_r    <= s1_c_r[6:2];
      s2_k_r    <= s1_c_r[1:0];
      s2_leap_r <= s2_leap_nxt;
      s2_inr_r  <= s1_inr_r;
    end
  end

  // stage 3: h = sum mod 30
  always_comb begin
    hq_prod  = 22'(s2_hsum_r) * 22'(emf_pkg::DIV30_MUL);
    hq       = hq_prod[20:16];
    h_full   = s2_hsum_r - 10'(hq) * 10'(30);
    s3_h_nxt = h_full[4:0];
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_h_r    <= s3_h_nxt;
      s3_a_r    <= s2_a_r;
      s3_e_r    <= s2_e_r;
      s3_i_r    <= s2_i_r;
      s3_k_r    <= s2_k_r;
      s3_leap_r <= s2_leap_r;
      s3_inr_r  <= s2_inr_r;
    end
  end

  // stage 4: weekday correction l = sum mod 7
  always_comb begin
    lsum     = 7'(emf_pkg::L_BIAS) + 7'({s3_e_r, 1'b0}) + 7'({s3_i_r, 1'b0})
               - 7'(s3_h_r) - 7'(s3_k_r);
    lq_prod  = 15'(lsum) * 15'(emf_pkg::DIV7_MUL);
    lq       = lq_prod[14:10];
    l_full   = lsum - 7'(lq) * 7'(7);
    s4_l_nxt = l_full[2:0];
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_l_r    <= s4_l_nxt;
      s4_h_r    <= s3_h_r;
      s4_a_r    <= s3_a_r;
      s4_leap_r <= s3_leap_r;
      s4_inr_r  <= s3_inr_r;
    end
  end

  // stage 5: m correction, Easter month and day
  always_comb begin
    msum        = 9'(s4_a_r) + 9'(s4_h_r) * 9'(11) + 9'(s4_l_r) * 9'(22);
    m_hit       = (msum >= 9'(emf_pkg::M_LIMIT));
    base        = 8'(s4_h_r) + 8'(s4_l_r) + 8'(emf_pkg::BASE_BIAS) - (m_hit ? 8'd7 : 8'd0);
    s5_apr_nxt  = (base >= 8'(emf_pkg::APR_BASE));
    edom_full   = s5_apr_nxt ? base - 8'(emf_pkg::APR_BASE - 1)
                             : base - 8'(emf_pkg::APR_BASE - 32);
    s5_edom_nxt = edom_full[4:0];
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_apr_r  <= s5_apr_nxt;
      s5_edom_r <= s5_edom_nxt;
      s5_leap_r <= s4_leap_r;
      s5_inr_r  <= s4_inr_r;
    end
  end

  // stage 6: day of year of Easter and of each feast
  always_comb begin
    eord        = 9'(s5_edom_r) + (s5_apr_r ? emf_pkg::END_MAR : emf_pkg::END_FEB)
                  + 9'(s5_leap_r);
    s6_carn_nxt = eord - 9'(emf_pkg::CARNIVAL_BACK);
    s6_fri_nxt  = eord - 9'(emf_pkg::FRIDAY_BACK);
    s6_asc_nxt  = eord + 9'(emf_pkg::ASCENSION_FWD);
    s6_pen_nxt  = eord + 9'(emf_pkg::PENTECOST_FWD);
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_apr_r  <= s5_apr_r;
      s6_edom_r <= s5_edom_r;
      s6_leap_r <= s5_leap_r;
      s6_inr_r  <= s5_inr_r;
      s6_carn_r <= s6_carn_nxt;
      s6_fri_r  <= s6_fri_nxt;
      s6_asc_r  <= s6_asc_nxt;
      s6_pen_r  <= s6_pen_nxt;
    end
  end

  // output stage: day of year back to month and day
  always_comb begin
    carn_d = emf_pkg::ord_to_date(s6_carn_r, s6_leap_r);
    fri_d  = emf_pkg::ord_to_date(s6_fri_r, s6_leap_r);
    asc_d  = emf_pkg::ord_to_date(s6_asc_r, s6_leap_r);
    pen_d  = emf_pkg::ord_to_date(s6_pen_r, s6_leap_r);
    out_nxt.year_in_range = s6_inr_r;
    out_nxt.leap_flag     = s6_leap_r;
    out_nxt.easter_dom    = s6_edom_r;
    out_nxt.easter_mon    = s6_apr_r ? emf_pkg::MON_APR : emf_pkg::MON_MAR;
    out_nxt.carnival_dom  = carn_d.dom;
    out_nxt.carnival_mon  = carn_d.mon[1:0];
    out_nxt.friday_dom    = fri_d.dom;
    out_nxt.friday_mon    = fri_d.mon;
    out_nxt.ascension_dom = asc_d.dom;
    out_nxt.ascension_mon = asc_d.mon;
    out_nxt.pentecost_dom = pen_d.dom;
    out_nxt.pentecost_mon = pen_d.mon;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_r <= out_nxt;
    end
  end

  // Easter day of month is never zero
  assert property (@(posedge clk) disable iff (!rst_n) s5_v_r |-> (s5_edom_r != 5'd0))
    else $error("easter day of month is zero");

  // carnival always lands in February or March
  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.carnival_mon == emf_pkg::MON_FEB[1:0] ||
                 out_r.carnival_mon == emf_pkg::MON_MAR[1:0]))
    else $error("carnival month out of range");

  // a finished item in stage 6 reaches the output register when it moves
  assert property (@(posedge clk) disable iff (!rst_n) (s6_v_r && en_out) |=> out_v_r)
    else $error("stage 6 transaction lost");

  // Whitsunday is in May or June
  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.pentecost_mon == emf_pkg::MON_MAY ||
                 out_r.pentecost_mon == emf_pkg::MON_JUN))
    else $error("whitsunday month out of range");

endmodule

/* rtl/easter_movable_feasts_unit.sv */
// Top level: Easter and movable feast dates for a Gregorian year
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in_     | input     | in_valid / in_ready  | in_year (14 bits)
//   out_    | output    | out_valid / out_ready| range, leap, Easter and four feasts
//
// One year per cycle is taken and one result per cycle is given while out_ready is high.
// From acceptance to out_valid, after the front register the item
//   moves through one queue slot, six back stages and the output register; the six back
//   stages follow the dependent steps of the computus.
// Reset (rst_n low, synchronous) empties the front register, the queue and all stages.
// A stall on out_ready backs up the back pipeline stage by stage; the front keeps
//   taking years until the queue between the two fills up.
`timescale 1ns / 1ps
module easter_movable_feasts_unit #(
  parameter int QUEUE_DEPTH = emf_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [emf_pkg::YEAR_W-1:0] in_year,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_year_in_range,
  output logic                       out_leap_flag,
  output logic [4:0]                 out_easter_dom,
  output logic [2:0]                 out_easter_mon,
  output logic [4:0]                 out_carnival_dom,
  output logic [1:0]                 out_carnival_mon,
  output logic [4:0]                 out_friday_dom,
  output logic [2:0]                 out_friday_mon,
  output logic [4:0]                 out_ascension_dom,
  output logic [2:0]                 out_ascension_mon,
  output logic [4:0]                 out_pentecost_dom,
  output logic [2:0]                 out_pentecost_mon
);

  logic                 push, full, pop, not_empty;
  emf_pkg::front_item_t push_item, pop_item;
  emf_pkg::result_t     res;

  // front: accept and prepare quotients
  emf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_year   (in_year),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  // queue between front and back
  emf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (not_empty)
  );

  // back: computus and feast dates
  emf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (not_empty),
    .q_item    (pop_item),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (res)
  );

  // result fields
  assign out_year_in_range = res.year_in_range;
  assign out_leap_flag     = res.leap_flag;
  assign out_easter_dom    = res.easter_dom;
  assign out_easter_mon    = res.easter_mon;
  assign out_carnival_dom  = res.carnival_dom;
  assign out_carnival_mon  = res.carnival_mon;
  assign out_friday_dom    = res.friday_dom;
  assign out_friday_mon    = res.friday_mon;
  assign out_ascension_dom = res.ascension_dom;
  assign out_ascension_mon = res.ascension_mon;
  assign out_pentecost_dom = res.pentecost_dom;
  assign out_pentecost_mon = res.pentecost_mon;

endmodule
